// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the coordinate converter.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, off while reset is asserted.
`define HTE_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property at each rising edge, reset included.
`define HTE_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hte_pkg.sv =====
// Field widths and fixed-point constants of the horizon to equatorial converter.
// Depends on nothing; used by the channel interfaces and the top level.
package hte_pkg;

  localparam int ZEN_W = 24;
  localparam int AZ_W  = 25;
  localparam int LST_W = 25;
  localparam int RA_W  = 25;
  localparam int DEC_W = 24;
  localparam int LAT_W = 24;

  localparam int CORDIC_STEPS = 24;
  localparam int ISQRT_STEPS  = 31;
  localparam int DIV_STEPS    = 30;

  // arctangent of 2^-k in degrees * 2^20
  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  localparam int CORDIC_GAIN  = 652032874;
  localparam int ONE_Q30      = 1073741824;
  localparam int FULL_TURN    = 377487360;
  localparam int HALF_TURN    = 188743680;
  localparam int QUARTER_TURN = 94371840;
  localparam int AZ_TURN      = 23592960;
  localparam int AZ_HALF      = 11796480;
  localparam int DAY_Q20      = 25165824;
  localparam int DEC_LIMIT    = 5898240;

  // floor(v / 15) = (v * RECIP15) >> RECIP_SH for v below 2^29
  localparam logic [29:0] RECIP15  = 30'd572662307;
  localparam int          RECIP_SH = 33;

endpackage

// ===== rtl/hte_if.sv =====
// Valid/ready channel interfaces of the horizon to equatorial converter.
// Depends on hte_pkg for the field widths.
interface hte_in_if;
  logic                      valid;
  logic                      ready;
  logic [hte_pkg::ZEN_W-1:0] zenith_angle;
  logic [hte_pkg::AZ_W-1:0]  azimuth_angle;
  logic [hte_pkg::LST_W-1:0] sidereal_hours;
  modport source (output valid, zenith_angle, azimuth_angle, sidereal_hours, input ready);
  modport sink (input valid, zenith_angle, azimuth_angle, sidereal_hours, output ready);
endinterface

interface hte_out_if;
  logic                             valid;
  logic                             ready;
  logic        [hte_pkg::RA_W-1:0]  right_ascension;
  logic signed [hte_pkg::DEC_W-1:0] declination;
  modport source (output valid, right_ascension, declination, input ready);
  modport sink (input valid, right_ascension, declination, output ready);
endinterface

interface hte_cfg_if;
  logic                             valid;
  logic                             ready;
  logic signed [hte_pkg::LAT_W-1:0] site_latitude;
  modport source (output valid, site_latitude, input ready);
  modport sink (input valid, site_latitude, output ready);
endinterface

// ===== rtl/horizon_to_equatorial.sv =====
// Horizon (zenith angle, azimuth, sidereal time) to equatorial (RA, dec) converter.
// Depends on hte_pkg, hte_if.sv and assert_macros.svh.
//
// Usage:
//   cfg_i  : write the site latitude (degrees * 2^16, signed); always ready.
//            Write it only while no transaction is in flight.
//   in_i   : carries zenith angle, azimuth and LST; one transaction per cycle while ready is high.
//   out_o  : right ascension (hours * 2^20) and declination (degrees * 2^16).
// Throughput is one transaction per cycle when out_o does not stall. The
// pipeline is a chain of rotation CORDICs, multipliers, two bit-per-stage
// square roots, a bit-per-stage divider and two vectoring CORDICs; the
// 24-step CORDICs, the 31-stage square roots and the 30-stage divider set
// the depth. All stages advance together: when out_o holds a valid result
// that is not taken, the whole pipeline holds and in_i.ready drops, so
// nothing is lost or repeated. Bubbles travel as stages with valid low.
// Reset clears the valid bits and sets the latitude to zero; no clearing pass
// is needed, the block keeps no other state.
`include "assert_macros.svh"

module horizon_to_equatorial (
  input  logic      clk_i,
  input  logic      rst_ni,
  hte_cfg_if.sink   cfg_i,
  hte_in_if.sink    in_i,
  hte_out_if.source out_o
);

  localparam int NROT = hte_pkg::CORDIC_STEPS;
  localparam int NSQ  = hte_pkg::ISQRT_STEPS;
  localparam int NDIV = hte_pkg::DIV_STEPS;
  localparam int NSTG = 1 + NROT + 6 + NSQ + (NROT + 1) + (NDIV + 2) + 3 + NSQ
                        + (NROT + 1) + 4;
  localparam logic signed [63:0] ONE_SQ = 64'sd1 <<< 60;

  typedef struct packed {
    logic signed [30:0] r;
    logic               neg;
  } red_t;

  typedef struct packed {
    red_t        lat;
    red_t        zen;
    red_t        az;
    logic        az_pos;
    logic [24:0] lst;
  } in_t;

  typedef struct packed {
    logic [2:0][33:0] x;
    logic [2:0][33:0] y;
    logic [2:0][30:0] r;
    logic [2:0]       neg;
    logic             az_pos;
    logic [24:0]      lst;
  } rot_t;

  typedef struct packed {
    logic signed [31:0] sl;
    logic signed [31:0] cl;
    logic signed [31:0] sz;
    logic signed [31:0] cz;
    logic signed [31:0] ca;
    logic signed [63:0] m1;
    logic signed [63:0] m2;
    logic signed [63:0] m3;
    logic signed [31:0] sd;
    logic signed [63:0] num;
    logic [61:0]        rad;
    logic               az_pos;
    logic [24:0]        lst;
  } mid_t;

  typedef struct packed {
    logic [61:0] n;
    logic [61:0] res;
  } sqr_t;

  typedef struct packed {
    sqr_t               s;
    logic signed [31:0] sd;
    logic signed [31:0] cl;
    logic signed [63:0] num;
    logic               az_pos;
    logic [24:0]        lst;
  } sqd_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [30:0] z;
  } vxyz_t;

  typedef struct packed {
    vxyz_t              v;
    logic signed [63:0] num;
    logic signed [63:0] den;
    logic               az_pos;
    logic [24:0]        lst;
  } vdec_t;

  typedef struct packed {
    logic [61:0]        r;
    logic [61:0]        ad;
    logic [29:0]        qb;
    logic               sgn;
    logic               nneg;
    logic               frc;
    logic               fneg;
    logic signed [23:0] dec;
    logic               az_pos;
    logic [24:0]        lst;
  } div_t;

  typedef struct packed {
    logic signed [31:0] q;
    logic signed [63:0] qq;
    logic [61:0]        rad;
    logic signed [23:0] dec;
    logic               az_pos;
    logic [24:0]        lst;
  } quo_t;

  typedef struct packed {
    sqr_t               s;
    logic signed [31:0] q;
    logic signed [23:0] dec;
    logic               az_pos;
    logic [24:0]        lst;
  } sqh_t;

  typedef struct packed {
    vxyz_t              v;
    logic signed [23:0] dec;
    logic               az_pos;
    logic [24:0]        lst;
  } vha_t;

  typedef struct packed {
    logic [28:0]        v;
    logic [58:0]        p;
    logic signed [26:0] d;
    logic [24:0]        ra;
    logic signed [23:0] dec;
    logic [24:0]        lst;
  } ra_t;

  // reduce an angle (degrees * 2^20) into [-90, 90] with a sign flag
  function automatic red_t reduce(logic signed [31:0] a);
    red_t               o;
    logic signed [31:0] w;
    w = a;
    o.neg = 1'b0;
    if (w >= hte_pkg::FULL_TURN) w = w - hte_pkg::FULL_TURN;
    if (w >= hte_pkg::HALF_TURN) w = w - hte_pkg::FULL_TURN;
    if (w > hte_pkg::QUARTER_TURN) begin
      w = w - hte_pkg::HALF_TURN;
      o.neg = 1'b1;
    end else if (w < -hte_pkg::QUARTER_TURN) begin
      w = w + hte_pkg::HALF_TURN;
      o.neg = 1'b1;
    end
    o.r = 31'(w);
    return o;
  endfunction

  function automatic rot_t rot_step(rot_t a, int k);
    rot_t               o;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [30:0] r;
    o = a;
    for (int l = 0; l < 3; l++) begin
      x = $signed(a.x[l]);
      y = $signed(a.y[l]);
      r = $signed(a.r[l]);
      if (r >= 0) begin
        o.x[l] = x - (y >>> k);
        o.y[l] = y + (x >>> k);
        o.r[l] = r - 31'(hte_pkg::ATAN_TAB[k]);
      end else begin
        o.x[l] = x + (y >>> k);
        o.y[l] = y - (x >>> k);
        o.r[l] = r + 31'(hte_pkg::ATAN_TAB[k]);
      end
    end
    return o;
  endfunction

  function automatic vxyz_t vec_step(vxyz_t a, int k);
    vxyz_t o;
    if (a.y > 0) begin
      o.x = a.x + (a.y >>> k);
      o.y = a.y - (a.x >>> k);
      o.z = a.z + 31'(hte_pkg::ATAN_TAB[k]);
    end else begin
      o.x = a.x - (a.y >>> k);
      o.y = a.y + (a.x >>> k);
      o.z = a.z - 31'(hte_pkg::ATAN_TAB[k]);
    end
    return o;
  endfunction

  function automatic sqr_t sqrt_step(sqr_t a, int k);
    sqr_t        o;
    logic [61:0] bit_v;
    logic [61:0] trial;
    bit_v = 62'(1) << (60 - 2 * k);
    trial = a.res + bit_v;
    if (a.n >= trial) begin
      o.n   = a.n - trial;
      o.res = (a.res >> 1) + bit_v;
    end else begin
      o.n   = a.n;
      o.res = a.res >> 1;
    end
    return o;
  endfunction

  function automatic sqd_t sqd_step(sqd_t a, int k);
    sqd_t o;
    o   = a;
    o.s = sqrt_step(a.s, k);
    return o;
  endfunction

  function automatic sqh_t sqh_step(sqh_t a, int k);
    sqh_t o;
    o   = a;
    o.s = sqrt_step(a.s, k);
    return o;
  endfunction

  function automatic vdec_t vdec_step(vdec_t a, int k);
    vdec_t o;
    o   = a;
    o.v = vec_step(a.v, k);
    return o;
  endfunction

  function automatic vha_t vha_step(vha_t a, int k);
    vha_t o;
    o   = a;
    o.v = vec_step(a.v, k);
    return o;
  endfunction

  // restoring division, one quotient bit per stage
  function automatic div_t div_step(div_t a);
    div_t o;
    o = a;
    if ({a.r[60:0], 1'b0} >= a.ad) begin
      o.r  = {a.r[60:0], 1'b0} - a.ad;
      o.qb = {a.qb[28:0], 1'b1};
    end else begin
      o.r  = {a.r[60:0], 1'b0};
      o.qb = {a.qb[28:0], 1'b0};
    end
    return o;
  endfunction

  // negate by the fold flag and saturate to the unit range
  function automatic logic signed [31:0] sat_unit(logic [33:0] v, logic neg);
    logic signed [33:0] w;
    w = neg ? -$signed(v) : $signed(v);
    if (w > hte_pkg::ONE_Q30) w = 34'(hte_pkg::ONE_Q30);
    else if (w < -hte_pkg::ONE_Q30) w = -34'(hte_pkg::ONE_Q30);
    return 32'(w);
  endfunction

  logic                    adv;
  logic [NSTG-1:0]         vld_q;
  logic signed [23:0]      lat_q;

  in_t   a_d, a_q;
  rot_t  b_init;
  rot_t  b_q [NROT];
  mid_t  c0_d, c1_d, c2_d, c3_d, c4_d, c5_d;
  mid_t  c0_q, c1_q, c2_q, c3_q, c4_q, c5_q;
  sqd_t  d_init;
  sqd_t  d_q [NSQ];
  vdec_t e_init;
  vdec_t e_q [NROT+1];
  div_t  f0_d, f1_d;
  div_t  f_q [NDIV+2];
  quo_t  g0_d, g1_d, g2_d;
  quo_t  g0_q, g1_q, g2_q;
  sqh_t  h_init;
  sqh_t  h_q [NSQ];
  vha_t  i_init;
  vha_t  i_q [NROT+1];
  ra_t   j0_d, j1_d, j2_d, j3_d;
  ra_t   j0_q, j1_q, j2_q, j3_q;

  // all stages move together; hold everything while a result waits
  assign adv         = !vld_q[NSTG-1] || out_o.ready;
  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= '0;
      vld_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        lat_q <= cfg_i.site_latitude;
      end
      if (adv) begin
        vld_q <= {vld_q[NSTG-2:0], in_i.valid};
      end
    end
  end

  // input reduction and quadrant test
  always_comb begin
    logic [24:0] azr;
    a_d.lat = reduce(32'($signed({lat_q, 4'b0000})));
    a_d.zen = reduce({4'b0000, in_i.zenith_angle, 4'b0000});
    a_d.az  = reduce({3'b000, in_i.azimuth_angle, 4'b0000});
    azr = (in_i.azimuth_angle >= 25'(hte_pkg::AZ_TURN))
          ? in_i.azimuth_angle - 25'(hte_pkg::AZ_TURN) : in_i.azimuth_angle;
    a_d.az_pos = (azr != '0) && (azr < 25'(hte_pkg::AZ_HALF));
    a_d.lst    = in_i.sidereal_hours;
  end

  always_comb begin
    b_init.x      = {3{34'(hte_pkg::CORDIC_GAIN)}};
    b_init.y      = '0;
    b_init.r      = {a_q.az.r, a_q.zen.r, a_q.lat.r};
    b_init.neg    = {a_q.az.neg, a_q.zen.neg, a_q.lat.neg};
    b_init.az_pos = a_q.az_pos;
    b_init.lst    = a_q.lst;
  end

  // sin(dec), 1 - sin(dec)^2 and the hour-angle numerator
  always_comb begin
    logic signed [31:0] t;
    logic signed [63:0] s;
    c0_d        = '0;
    c0_d.sl     = sat_unit(b_q[NROT-1].y[0], b_q[NROT-1].neg[0]);
    c0_d.cl     = sat_unit(b_q[NROT-1].x[0], b_q[NROT-1].neg[0]);
    c0_d.sz     = sat_unit(b_q[NROT-1].y[1], b_q[NROT-1].neg[1]);
    c0_d.cz     = sat_unit(b_q[NROT-1].x[1], b_q[NROT-1].neg[1]);
    c0_d.ca     = sat_unit(b_q[NROT-1].x[2], b_q[NROT-1].neg[2]);
    c0_d.az_pos = b_q[NROT-1].az_pos;
    c0_d.lst    = b_q[NROT-1].lst;

    c1_d    = c0_q;
    c1_d.m1 = c0_q.cz * c0_q.sl;
    c1_d.m2 = c0_q.sz * c0_q.cl;

    t       = 32'(c1_q.m2 >>> 30);
    c2_d    = c1_q;
    c2_d.m3 = t * c1_q.ca;

    s = (c2_q.m1 + c2_q.m3 + 64'sd536870912) >>> 30;
    if (s > hte_pkg::ONE_Q30) s = 64'(hte_pkg::ONE_Q30);
    else if (s < -hte_pkg::ONE_Q30) s = -64'(hte_pkg::ONE_Q30);
    c3_d    = c2_q;
    c3_d.sd = 32'(s);

    c4_d    = c3_q;
    c4_d.m1 = c3_q.sd * c3_q.sd;
    c4_d.m2 = c3_q.sl * c3_q.sd;

    c5_d     = c4_q;
    c5_d.rad = 62'(ONE_SQ - c4_q.m1);
    c5_d.num = (64'(c4_q.cz) <<< 30) - c4_q.m2;
  end

  always_comb begin
    d_init.s.n   = c5_q.rad;
    d_init.s.res = '0;
    d_init.sd    = c5_q.sd;
    d_init.cl    = c5_q.cl;
    d_init.num   = c5_q.num;
    d_init.az_pos = c5_q.az_pos;
    d_init.lst   = c5_q.lst;
  end

  // cos(dec) is non-negative, so no quadrant pre-rotation is needed here
  always_comb begin
    logic signed [31:0] cd;
    cd            = 32'(d_q[NSQ-1].s.res);
    e_init.v.x    = 34'(cd);
    e_init.v.y    = 34'(d_q[NSQ-1].sd);
    e_init.v.z    = '0;
    e_init.num    = d_q[NSQ-1].num;
    e_init.den    = d_q[NSQ-1].cl * cd;
    e_init.az_pos = d_q[NSQ-1].az_pos;
    e_init.lst    = d_q[NSQ-1].lst;
  end

  // declination rounding, quotient magnitudes and saturation cases
  always_comb begin
    logic signed [30:0] dz;
    logic signed [63:0] nm;
    logic signed [63:0] dn;
    nm = e_q[NROT].num;
    dn = e_q[NROT].den;
    dz = (e_q[NROT].v.z + 31'sd8) >>> 4;
    if (dz > hte_pkg::DEC_LIMIT) dz = 31'(hte_pkg::DEC_LIMIT);
    else if (dz < -hte_pkg::DEC_LIMIT) dz = -31'(hte_pkg::DEC_LIMIT);
    f0_d        = '0;
    f0_d.dec    = 24'(dz);
    f0_d.r      = 62'(nm < 0 ? -nm : nm);
    f0_d.ad     = 62'(dn < 0 ? -dn : dn);
    f0_d.nneg   = nm < 0;
    f0_d.sgn    = (nm < 0) != (dn < 0);
    f0_d.az_pos = e_q[NROT].az_pos;
    f0_d.lst    = e_q[NROT].lst;

    f1_d      = f_q[0];
    f1_d.frc  = (f_q[0].ad == '0) || (f_q[0].r >= f_q[0].ad);
    f1_d.fneg = (f_q[0].ad == '0) ? f_q[0].nneg : f_q[0].sgn;
  end

  always_comb begin
    logic signed [31:0] qs;
    qs = 32'({2'b00, f_q[NDIV+1].qb});
    g0_d = '0;
    if (f_q[NDIV+1].frc) begin
      g0_d.q = f_q[NDIV+1].fneg ? -32'(hte_pkg::ONE_Q30) : 32'(hte_pkg::ONE_Q30);
    end else begin
      g0_d.q = f_q[NDIV+1].sgn ? -qs : qs;
    end
    g0_d.dec    = f_q[NDIV+1].dec;
    g0_d.az_pos = f_q[NDIV+1].az_pos;
    g0_d.lst    = f_q[NDIV+1].lst;

    g1_d    = g0_q;
    g1_d.qq = g0_q.q * g0_q.q;

    g2_d     = g1_q;
    g2_d.rad = 62'(ONE_SQ - g1_q.qq);
  end

  always_comb begin
    h_init.s.n    = g2_q.rad;
    h_init.s.res  = '0;
    h_init.q      = g2_q.q;
    h_init.dec    = g2_q.dec;
    h_init.az_pos = g2_q.az_pos;
    h_init.lst    = g2_q.lst;
  end

  // hour angle: atan2(sqrt(1 - q^2), q), turn a left-half vector first
  always_comb begin
    logic signed [33:0] x;
    logic signed [33:0] y;
    x = 34'(h_q[NSQ-1].q);
    y = 34'(h_q[NSQ-1].s.res);
    i_init.v.x = x;
    i_init.v.y = y;
    i_init.v.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        i_init.v.x = y;
        i_init.v.y = -x;
        i_init.v.z = 31'(hte_pkg::QUARTER_TURN);
      end else begin
        i_init.v.x = -y;
        i_init.v.y = x;
        i_init.v.z = -31'(hte_pkg::QUARTER_TURN);
      end
    end
    i_init.dec    = h_q[NSQ-1].dec;
    i_init.az_pos = h_q[NSQ-1].az_pos;
    i_init.lst    = h_q[NSQ-1].lst;
  end

  // mirror, convert to hours, subtract from LST and wrap into one day
  always_comb begin
    logic signed [30:0] z;
    logic [28:0]        ha;
    z = i_q[NROT].v.z;
    if (z < 0) z = '0;
    else if (z > hte_pkg::HALF_TURN) z = 31'(hte_pkg::HALF_TURN);
    ha = 29'(z);
    if (i_q[NROT].az_pos) ha = 29'(hte_pkg::FULL_TURN) - ha;
    j0_d     = '0;
    j0_d.v   = ha + 29'd7;
    j0_d.dec = i_q[NROT].dec;
    j0_d.lst = i_q[NROT].lst;

    j1_d   = j0_q;
    j1_d.p = j0_q.v * hte_pkg::RECIP15;

    j2_d   = j1_q;
    j2_d.d = 27'({2'b00, j1_q.lst}) - 27'({1'b0, j1_q.p[58:hte_pkg::RECIP_SH]});

    j3_d = j2_q;
    if (j2_q.d < 0) j3_d.ra = 25'(j2_q.d + hte_pkg::DAY_Q20);
    else if (j2_q.d >= hte_pkg::DAY_Q20) j3_d.ra = 25'(j2_q.d - hte_pkg::DAY_Q20);
    else j3_d.ra = 25'(j2_q.d);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q    <= a_d;
      b_q[0] <= rot_step(b_init, 0);
      for (int k = 1; k < NROT; k++) begin
        b_q[k] <= rot_step(b_q[k-1], k);
      end
      c0_q <= c0_d;
      c1_q <= c1_d;
      c2_q <= c2_d;
      c3_q <= c3_d;
      c4_q <= c4_d;
      c5_q <= c5_d;
      d_q[0] <= sqd_step(d_init, 0);
      for (int k = 1; k < NSQ; k++) begin
        d_q[k] <= sqd_step(d_q[k-1], k);
      end
      e_q[0] <= e_init;
      for (int k = 0; k < NROT; k++) begin
        e_q[k+1] <= vdec_step(e_q[k], k);
      end
      f_q[0] <= f0_d;
      f_q[1] <= f1_d;
      for (int k = 2; k < NDIV + 2; k++) begin
        f_q[k] <= div_step(f_q[k-1]);
      end
      g0_q <= g0_d;
      g1_q <= g1_d;
      g2_q <= g2_d;
      h_q[0] <= sqh_step(h_init, 0);
      for (int k = 1; k < NSQ; k++) begin
        h_q[k] <= sqh_step(h_q[k-1], k);
      end
      i_q[0] <= i_init;
      for (int k = 0; k < NROT; k++) begin
        i_q[k+1] <= vha_step(i_q[k], k);
      end
      j0_q <= j0_d;
      j1_q <= j1_d;
      j2_q <= j2_d;
      j3_q <= j3_d;
    end
  end

  assign out_o.valid           = vld_q[NSTG-1];
  assign out_o.right_ascension = j3_q.ra;
  assign out_o.declination     = j3_q.dec;

  `HTE_ASSERT_NR(a_reset_empty, clk_i, !rst_ni |-> !out_o.valid, "output valid in reset")
  `HTE_ASSERT(a_fire_enters, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> vld_q[0], "lost transaction")
  `HTE_ASSERT(a_stall_blocks, clk_i, rst_ni, (out_o.valid && !out_o.ready) |-> !in_i.ready, "input taken in stall")
  `HTE_ASSERT(a_dec_range, clk_i, rst_ni, out_o.valid |-> (out_o.declination <= hte_pkg::DEC_LIMIT && out_o.declination >= -hte_pkg::DEC_LIMIT), "dec range")
  `HTE_ASSERT(a_ra_range, clk_i, rst_ni, out_o.valid |-> (out_o.right_ascension < hte_pkg::DAY_Q20), "ra range")

endmodule

// ===== tb/tb_horizon_to_equatorial.sv =====
// Self-checking testbench for the horizon to equatorial converter.
// Depends on hte_pkg, hte_if.sv and horizon_to_equatorial; predicts RA and dec
// from its own fixed-point CORDIC model and checks every output transaction.
`timescale 1ns / 100ps

module tb_horizon_to_equatorial;

  localparam longint ONE    = 64'sd1073741824;
  localparam longint FULL   = 64'sd377487360;
  localparam longint HALF   = 64'sd188743680;
  localparam longint QUART  = 64'sd94371840;
  localparam longint DAY    = 64'sd25165824;
  localparam longint DECLIM = 64'sd5898240;
  localparam longint AZFULL = 64'sd23592960;
  localparam longint AZHALF = 64'sd11796480;
  localparam int     DRAIN  = 220;
  localparam int     LIMIT  = 2000000;

  typedef struct packed {
    logic [hte_pkg::ZEN_W-1:0] zen;
    logic [hte_pkg::AZ_W-1:0]  az;
    logic [hte_pkg::LST_W-1:0] lst;
  } pointing_t;

  typedef struct packed {
    logic        [hte_pkg::RA_W-1:0]  ra;
    logic signed [hte_pkg::DEC_W-1:0] dec;
  } radec_t;

  logic clk_i;
  logic rst_ni;

  hte_cfg_if cfg_ch ();
  hte_in_if  in_ch ();
  hte_out_if out_ch ();

  horizon_to_equatorial DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch.sink),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  pointing_t pending_q[$];
  radec_t    radec_q[$];
  longint    latitude;
  bit        quiet;
  bit        failed;
  int        cycles;

  function automatic longint isqrt64(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   -= res + b;
        res  = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // rotation CORDIC: sine and cosine (Q30) of degrees * 2^20
  function automatic void rotate(input longint a, output longint s, output longint c);
    longint r, x, y, dx, dy;
    bit     flip;
    r    = a % FULL;
    x    = hte_pkg::CORDIC_GAIN;
    y    = 0;
    flip = 0;
    if (r < 0) r += FULL;
    if (r >= HALF) r -= FULL;
    if (r > QUART) begin
      r -= HALF;
      flip = 1;
    end else if (r < -QUART) begin
      r += HALF;
      flip = 1;
    end
    for (int i = 0; i < hte_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= hte_pkg::ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; r += hte_pkg::ATAN_TAB[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = clip(y, -ONE, ONE);
    c = clip(x, -ONE, ONE);
  endfunction

  // vectoring CORDIC: angle of (x, y) in degrees * 2^20
  function automatic longint vector_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = QUART;
      end else begin
        x = -y; y = t; z = -QUART;
      end
    end
    for (int i = 0; i < hte_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += hte_pkg::ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= hte_pkg::ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic radec_t convert(pointing_t p, longint lat);
    longint sl, cl, sz, cz, sa, ca, sd, cd, dec20, num, den, q, ha, hah, ra, azr;
    longint dec16;
    longint unsigned an, ad, rem, qb;
    radec_t res;
    rotate(lat * 16, sl, cl);
    rotate(longint'(p.zen) * 16, sz, cz);
    rotate(longint'(p.az) * 16, sa, ca);
    sd    = cz * sl + ((sz * cl) >>> 30) * ca;
    sd    = clip((sd + (64'sd1 << 29)) >>> 30, -ONE, ONE);
    cd    = isqrt64(ONE * ONE - sd * sd);
    dec20 = vector_angle(sd, cd);
    num   = cz * ONE - sl * sd;
    den   = cl * cd;
    an    = num < 0 ? -num : num;
    ad    = den < 0 ? -den : den;
    if (ad == 0) begin
      q = num < 0 ? -ONE : ONE;
    end else if (an >= ad) begin
      q = ((num < 0) != (den < 0)) ? -ONE : ONE;
    end else begin
      rem = an;
      qb  = 0;
      for (int i = 0; i < hte_pkg::DIV_STEPS; i++) begin
        rem <<= 1;
        qb  <<= 1;
        if (rem >= ad) begin
          rem -= ad;
          qb  |= 1;
        end
      end
      q = ((num < 0) != (den < 0)) ? -longint'(qb) : longint'(qb);
    end
    ha  = clip(vector_angle(isqrt64(ONE * ONE - q * q), q), 0, HALF);
    azr = longint'(p.az) % AZFULL;
    // mirror the hour angle when sin(az) is positive
    if (azr > 0 && azr < AZHALF) ha = FULL - ha;
    hah = (ha + 7) / 15;
    ra  = (longint'(p.lst) - hah) % DAY;
    if (ra < 0) ra += DAY;
    dec16   = clip((dec20 + 8) >>> 4, -DECLIM, DECLIM);
    res.ra  = ra[hte_pkg::RA_W-1:0];
    res.dec = dec16[hte_pkg::DEC_W-1:0];
    return res;
  endfunction

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // driver: present queued pointings, predict on each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid          <= 0;
      in_ch.zenith_angle   <= '0;
      in_ch.azimuth_angle  <= '0;
      in_ch.sidereal_hours <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        radec_q.push_back(convert({in_ch.zenith_angle, in_ch.azimuth_angle,
                                   in_ch.sidereal_hours}, latitude));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 13)) begin
          pointing_t p;
          p = pending_q.pop_front();
          in_ch.zenith_angle   <= p.zen;
          in_ch.azimuth_angle  <= p.az;
          in_ch.sidereal_hours <= p.lst;
          in_ch.valid          <= 1;
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // monitor: random backpressure, compare against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (radec_q.size() == 0) begin
          $error("unexpected output transaction ra=%0d dec=%0d",
                 out_ch.right_ascension, out_ch.declination);
          failed = 1;
        end else begin
          radec_t e;
          e = radec_q.pop_front();
          if (out_ch.right_ascension !== e.ra) begin
            $error("right_ascension: expected %0d, got %0d", e.ra,
                   out_ch.right_ascension);
            failed = 1;
          end
          if (out_ch.declination !== e.dec) begin
            $error("declination: expected %0d, got %0d", e.dec, out_ch.declination);
            failed = 1;
          end
        end
      end
      out_ch.ready <= quiet || $urandom_range(99) >= 13;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_latitude(longint v);
    cfg_ch.site_latitude <= v[hte_pkg::LAT_W-1:0];
    cfg_ch.valid         <= 1;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    latitude     = v;
    cfg_ch.valid <= 0;
  endtask

  task automatic add_pointing(longint zen, longint az, longint lst);
    pointing_t p;
    p.zen = zen[hte_pkg::ZEN_W-1:0];
    p.az  = az[hte_pkg::AZ_W-1:0];
    p.lst = lst[hte_pkg::LST_W-1:0];
    pending_q.push_back(p);
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_ch.valid || radec_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  initial begin
    longint lat_list[7];
    longint zen, az, lst;
    lat_list = '{0, 5898240, -5898240, 8388607, -8388608, 0, 2949120};
    lat_list[5]          = longint'($urandom_range(11796480)) - 5898240;
    rst_ni               = 0;
    failed               = 0;
    quiet                = 0;
    latitude             = 0;
    cfg_ch.valid         = 0;
    cfg_ch.site_latitude = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    foreach (lat_list[k]) begin
      write_latitude(lat_list[k]);
      // hold off stalls for the whole of one phase
      quiet = (k == 3);
      if (k == 0 || k == 1 || k == 4) begin
        add_pointing(0, 0, 0);
        add_pointing(11796480, 11796480, 25165823);
        add_pointing(24'hFFFFFF, 25'h1FFFFFF, 25'h1FFFFFF);
        add_pointing(0, 5898240, 12582912);
        add_pointing(5898240, 17694720, 1);
        add_pointing(2949120, 23592960, 25165824);
        add_pointing(5898240, 23592959, 0);
        add_pointing(0, 11796480, 100);
      end
      repeat (180) begin
        zen = $urandom_range(7) == 0 ? $urandom_range(24'hFFFFFF) : $urandom_range(11796480);
        az  = $urandom_range(7) == 0 ? $urandom_range(25'h1FFFFFF) : $urandom_range(23592959);
        lst = $urandom_range(7) == 0 ? $urandom_range(25'h1FFFFFF) : $urandom_range(25165823);
        add_pointing(zen, az, lst);
      end
      wait_drained();
    end
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
